// File: rtl/cdb_pkg.sv
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared constants for the circular deque buffer: field widths, command and
// status codes, and default sizes for the storage.
// ----------------------------------------------------------------------------
package cdb_pkg;

    // default storage size
    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // beat field widths
    localparam int CMD_W  = 3;
    localparam int POS_W  = 12;
    localparam int VAL_W  = 32;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 11;

    // packed tdata widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET        = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET        = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

// File: rtl/cdb_ram.sv
// ----------------------------------------------------------------------------
// cdb_ram
// Generic single-clock RAM, one write and one read port, registered read.
// A read and a write to the same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module cdb_ram #(
    parameter int WIDTH = cdb_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = cdb_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, read-first
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/circular_deque_buffer.sv
// ----------------------------------------------------------------------------
// circular_deque_buffer
// Double-ended ring buffer of fixed depth: push and pop at either end, read
// or replace by logical index from the front, one result beat per command.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)              tuser
//  s_axis   in   position[11:0], value[43:12]    cmd[2:0]
//  m_axis   out  data[31:0], count[42:32]        status[1:0]
//
//  Pushes, failed commands and unused codes load the result register directly;
//  pops, gets and replacing sets wait in S_READ for the registered RAM read.
//  One command is in flight at a time; a new one is taken while the previous
//  result still sits in the output register, provided it leaves that cycle.
//  Reset (synchronous, active low) empties the buffer; slot contents are not
//  cleared. A stalled master side holds the result and blocks new commands.
// ----------------------------------------------------------------------------
module circular_deque_buffer #(
    parameter int DEPTH      = cdb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdb_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // position[11:0], value[43:12], zero pad above
    input  logic [cdb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // cmd[2:0]
    input  logic [cdb_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // data[31:0], count[42:32], zero pad above
    output logic [cdb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [cdb_pkg::STAT_W-1:0]       m_axis_tuser
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int MAGW = cdb_pkg::POS_W - 1;
    localparam int CMPW = (CW > MAGW) ? CW : MAGW;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // state codes
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_occ;
    logic          r_out_valid;
    logic [cdb_pkg::DATA_W-1:0] r_data;
    logic [cdb_pkg::STAT_W-1:0] r_status;
    logic [cdb_pkg::CNT_W-1:0]  r_count;

    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_occ;
    logic [cdb_pkg::STAT_W-1:0] n_status;
    logic n_need_rd;

    logic [cdb_pkg::CMD_W-1:0]  w_cmd;
    logic [cdb_pkg::POS_W-1:0]  w_pos;
    logic [DATA_WIDTH-1:0]      w_value;
    logic [CMPW-1:0]            w_pos_x;
    logic [CMPW-1:0]            w_occ_x;
    logic                       w_neg;
    logic                       w_minus1;
    logic                       w_full;
    logic                       w_empty;
    logic [AW-1:0] w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;
    logic [AW:0]   w_sum;
    logic [AW-1:0] w_phys;

    logic                  w_accept;
    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    // beat fields
    assign w_cmd   = s_axis_tuser;
    assign w_pos   = s_axis_tdata[cdb_pkg::POS_W-1:0];
    assign w_value = DATA_WIDTH'(s_axis_tdata[cdb_pkg::POS_W +: cdb_pkg::VAL_W]);

    assign w_neg    = w_pos[cdb_pkg::POS_W-1];
    assign w_minus1 = &w_pos;
    assign w_pos_x  = CMPW'(w_pos[MAGW-1:0]);
    assign w_occ_x  = CMPW'(r_occ);
    assign w_full   = (r_occ == FULL_CNT);
    assign w_empty  = (r_occ == '0);

    // wrapped pointer neighbours
    assign w_head_inc = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign w_head_dec = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign w_tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
    assign w_tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - AW'(1);

    // logical index to slot address; only used when the index is in range
    assign w_sum  = (AW + 1)'(r_head) + (AW + 1)'(AW'(w_pos_x));
    assign w_phys = (w_sum >= DEPTH_X) ? AW'(w_sum - DEPTH_X) : AW'(w_sum);

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // command decode: pointer updates, slot accesses and status
    always_comb begin
        logic do_pf;
        logic do_pb;
        do_pf     = 1'b0;
        do_pb     = 1'b0;
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_status  = cdb_pkg::ST_OK;
        n_need_rd = 1'b0;
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_waddr   = r_tail;
        w_raddr   = r_head;
        case (w_cmd)
            cdb_pkg::CMD_PUSH_FRONT: begin
                do_pf = 1'b1;
            end
            cdb_pkg::CMD_PUSH_BACK: begin
                do_pb = 1'b1;
            end
            cdb_pkg::CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_status = cdb_pkg::ST_EMPTY;
                end else begin
                    w_re      = 1'b1;
                    w_raddr   = r_head;
                    n_head    = w_head_inc;
                    n_occ     = r_occ - CW'(1);
                    n_need_rd = 1'b1;
                end
            end
            cdb_pkg::CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = cdb_pkg::ST_EMPTY;
                end else begin
                    w_re      = 1'b1;
                    w_raddr   = w_tail_dec;
                    n_tail    = w_tail_dec;
                    n_occ     = r_occ - CW'(1);
                    n_need_rd = 1'b1;
                end
            end
            cdb_pkg::CMD_GET: begin
                if (w_neg || (w_pos_x >= w_occ_x)) begin
                    n_status = cdb_pkg::ST_RANGE;
                end else begin
                    w_re      = 1'b1;
                    w_raddr   = w_phys;
                    n_need_rd = 1'b1;
                end
            end
            cdb_pkg::CMD_SET: begin
                if (!w_neg && (w_pos_x == w_occ_x)) begin
                    do_pb = 1'b1;
                end else if (w_minus1) begin
                    do_pf = 1'b1;
                end else if (w_neg || (w_pos_x > w_occ_x)) begin
                    n_status = cdb_pkg::ST_RANGE;
                end else begin
                    // replace: the RAM returns the old word, writes the new
                    w_re      = 1'b1;
                    w_raddr   = w_phys;
                    w_we      = 1'b1;
                    w_waddr   = w_phys;
                    n_need_rd = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // shared push paths
        if (do_pf) begin
            if (w_full) begin
                n_status = cdb_pkg::ST_FULL;
            end else begin
                w_we    = 1'b1;
                w_waddr = w_head_dec;
                n_head  = w_head_dec;
                n_occ   = r_occ + CW'(1);
            end
        end
        if (do_pb) begin
            if (w_full) begin
                n_status = cdb_pkg::ST_FULL;
            end else begin
                w_we    = 1'b1;
                w_waddr = r_tail;
                n_tail  = w_tail_inc;
                n_occ   = r_occ + CW'(1);
            end
        end
    end

    // slot storage
    cdb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_value),
        .i_re    (w_accept && w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // pointers, sequencer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_state     <= n_need_rd ? S_READ : S_IDLE;
            r_out_valid <= !n_need_rd;
        end else if (r_state == S_READ) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data   <= '0;
            r_status <= n_status;
            r_count  <= cdb_pkg::CNT_W'(n_occ);
        end else if (r_state == S_READ) begin
            r_data   <= cdb_pkg::DATA_W'(w_rdata);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = cdb_pkg::OUT_TDATA_W'({r_count, r_data});
    assign m_axis_tuser  = r_status;

endmodule

// File: tb/tb_circular_deque_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque_buffer
// Self-checking bench for the circular deque buffer. Command beats come from
// a queue filled phase by phase, first directed cases, then random traffic
// that walks the buffer up to full. A shadow deque predicts each
// result beat, and the monitor compares it field by field. Sender gaps,
// receiver stalls and one long receiver hold-off vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_circular_deque_buffer;

    localparam int DEPTH          = cdb_pkg::DEPTH_DEF;
    localparam int HOLD_LEN       = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_PAUSE      = 20;
    localparam int MIXED_LEN      = 24;

    // codes the block treats as no operation
    localparam logic [cdb_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [cdb_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [cdb_pkg::CMD_W-1:0]        cmd;
        logic signed [cdb_pkg::POS_W-1:0] pos;
        logic [cdb_pkg::VAL_W-1:0]        val;
    } t_deque_cmd;

    typedef struct {
        logic [cdb_pkg::DATA_W-1:0] data;
        logic [cdb_pkg::STAT_W-1:0] status;
        logic [cdb_pkg::CNT_W-1:0]  count;
    } t_deque_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [cdb_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // position, value, zero pad
    logic [cdb_pkg::CMD_W-1:0]       s_axis_tuser = '0;   // cmd
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [cdb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // data, count, zero pad
    logic [cdb_pkg::STAT_W-1:0]      m_axis_tuser;        // status

    circular_deque_buffer #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (cdb_pkg::DATA_WIDTH_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // bench state
    t_deque_cmd    cmd_queue[$];
    t_deque_result result_queue[$];
    t_deque_cmd    beat_on_bus;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_asks = 0;
    int            hold_seen = 0;
    int            hold_left = 0;
    int            quiet_cycles = 0;
    int            error_count = 0;
    int            gen_fill = 0;

    // shadow deque
    logic [cdb_pkg::DATA_W-1:0] slot_mem [DEPTH];
    int                         front_ptr = 0;
    int                         back_ptr = 0;
    int                         held = 0;

    function automatic logic [cdb_pkg::STAT_W-1:0] add_front_word(
        input logic [cdb_pkg::VAL_W-1:0] val);
        if (held >= DEPTH)
            return cdb_pkg::ST_FULL;
        front_ptr = (front_ptr == 0) ? DEPTH - 1 : front_ptr - 1;
        slot_mem[front_ptr] = val;
        held++;
        return cdb_pkg::ST_OK;
    endfunction

    function automatic logic [cdb_pkg::STAT_W-1:0] add_back_word(
        input logic [cdb_pkg::VAL_W-1:0] val);
        if (held >= DEPTH)
            return cdb_pkg::ST_FULL;
        slot_mem[back_ptr] = val;
        back_ptr = (back_ptr + 1) % DEPTH;
        held++;
        return cdb_pkg::ST_OK;
    endfunction

    // apply one command to the shadow deque and return the result beat it causes
    function automatic t_deque_result apply_command(input t_deque_cmd c);
        t_deque_result r;
        int            idx;
        int            phys;
        idx = c.pos;
        r.data = '0;
        r.status = cdb_pkg::ST_OK;
        case (c.cmd)
            cdb_pkg::CMD_PUSH_FRONT: r.status = add_front_word(c.val);
            cdb_pkg::CMD_PUSH_BACK:  r.status = add_back_word(c.val);
            cdb_pkg::CMD_POP_FRONT: begin
                if (held == 0) begin
                    r.status = cdb_pkg::ST_EMPTY;
                end else begin
                    r.data = slot_mem[front_ptr];
                    front_ptr = (front_ptr + 1) % DEPTH;
                    held--;
                end
            end
            cdb_pkg::CMD_POP_BACK: begin
                if (held == 0) begin
                    r.status = cdb_pkg::ST_EMPTY;
                end else begin
                    back_ptr = (back_ptr == 0) ? DEPTH - 1 : back_ptr - 1;
                    r.data = slot_mem[back_ptr];
                    held--;
                end
            end
            cdb_pkg::CMD_GET: begin
                if (idx < 0 || idx >= held)
                    r.status = cdb_pkg::ST_RANGE;
                else
                    r.data = slot_mem[(front_ptr + idx) % DEPTH];
            end
            cdb_pkg::CMD_SET: begin
                // append is tested first, so index 0 on an empty deque appends
                if (idx >= 0 && idx == held) begin
                    r.status = add_back_word(c.val);
                end else if (idx == -1) begin
                    r.status = add_front_word(c.val);
                end else if (idx < 0 || idx > held) begin
                    r.status = cdb_pkg::ST_RANGE;
                end else begin
                    phys = (front_ptr + idx) % DEPTH;
                    r.data = slot_mem[phys];
                    slot_mem[phys] = c.val;
                end
            end
            default: ;
        endcase
        r.count = held[cdb_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic logic [cdb_pkg::IN_TDATA_W-1:0] pack_cmd(input t_deque_cmd c);
        logic [cdb_pkg::IN_TDATA_W-1:0] w;
        w = '0;
        w[cdb_pkg::POS_W-1:0] = c.pos;
        w[cdb_pkg::POS_W +: cdb_pkg::VAL_W] = c.val;
        return w;
    endfunction

    task automatic flag_error(input string what);
        $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    // driver: next beat from the queue, with random gaps between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                result_queue.push_back(apply_command(beat_on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    beat_on_bus = cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pack_cmd(beat_on_bus);
                    s_axis_tuser  <= beat_on_bus.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin : check_beat
                t_deque_result want;
                if (result_queue.size() == 0) begin
                    flag_error("result beat with nothing expected");
                end else begin
                    want = result_queue.pop_front();
                    if (m_axis_tdata[cdb_pkg::DATA_W-1:0] !== want.data)
                        flag_error($sformatf("data got %h want %h",
                                             m_axis_tdata[cdb_pkg::DATA_W-1:0],
                                             want.data));
                    if (m_axis_tuser !== want.status)
                        flag_error($sformatf("status got %0d want %0d",
                                             m_axis_tuser, want.status));
                    if (m_axis_tdata[cdb_pkg::DATA_W +: cdb_pkg::CNT_W] !== want.count)
                        flag_error($sformatf("count got %0d want %0d",
                                             m_axis_tdata[cdb_pkg::DATA_W +: cdb_pkg::CNT_W],
                                             want.count));
                end
            end
            // long hold-off on request, else random stalls
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_circular_deque_buffer: done, errors");
            $finish;
        end
    end

    // queue one command and track the fill it leaves behind
    task automatic queue_cmd(input logic [cdb_pkg::CMD_W-1:0] cmd, input int pos,
                             input logic [cdb_pkg::VAL_W-1:0] val);
        t_deque_cmd c;
        c.cmd = cmd;
        c.pos = pos[cdb_pkg::POS_W-1:0];
        c.val = val;
        cmd_queue.push_back(c);
        case (cmd)
            cdb_pkg::CMD_PUSH_FRONT, cdb_pkg::CMD_PUSH_BACK:
                if (gen_fill < DEPTH) gen_fill++;
            cdb_pkg::CMD_POP_FRONT, cdb_pkg::CMD_POP_BACK:
                if (gen_fill > 0) gen_fill--;
            cdb_pkg::CMD_SET:
                if ((pos == gen_fill || pos == -1) && gen_fill < DEPTH) gen_fill++;
            default: ;
        endcase
    endtask

    function automatic logic [cdb_pkg::VAL_W-1:0] rand_word();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic int noise_pos();
        return $urandom_range(0, 4095) - 2048;
    endfunction

    // mostly valid indexes, some appends, prepends and noise
    function automatic int pick_index();
        int k;
        k = $urandom_range(0, 9);
        if (k <= 6 && gen_fill > 0)
            return $urandom_range(0, gen_fill - 1);
        if (k == 7)
            return gen_fill;
        if (k == 8)
            return -1;
        return noise_pos();
    endfunction

    task automatic gen_mixed(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 20)
                queue_cmd(cdb_pkg::CMD_PUSH_FRONT, noise_pos(), rand_word());
            else if (r < 40)
                queue_cmd(cdb_pkg::CMD_PUSH_BACK, noise_pos(), rand_word());
            else if (r < 55)
                queue_cmd(cdb_pkg::CMD_POP_FRONT, noise_pos(), rand_word());
            else if (r < 70)
                queue_cmd(cdb_pkg::CMD_POP_BACK, noise_pos(), rand_word());
            else if (r < 83)
                queue_cmd(cdb_pkg::CMD_GET, pick_index(), rand_word());
            else if (r < 96)
                queue_cmd(cdb_pkg::CMD_SET, pick_index(), rand_word());
            else
                queue_cmd(r[0] ? CMD_SPARE_7 : CMD_SPARE_6, noise_pos(), rand_word());
        end
    endtask

    // grow the deque to full by every route that inserts
    task automatic fill_to_full();
        int r;
        while (gen_fill < DEPTH) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                queue_cmd(cdb_pkg::CMD_PUSH_FRONT, noise_pos(), rand_word());
            else if (r < 70)
                queue_cmd(cdb_pkg::CMD_PUSH_BACK, noise_pos(), rand_word());
            else if (r < 85)
                queue_cmd(cdb_pkg::CMD_SET, gen_fill, rand_word());
            else
                queue_cmd(cdb_pkg::CMD_SET, -1, rand_word());
        end
    endtask

    // wait until every beat is out, sampling at the quiet point between edges
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_axis_tvalid || result_queue.size() != 0)
            @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty deque, both ends, index bounds, spare codes
        queue_cmd(cdb_pkg::CMD_POP_FRONT, 0, '0);
        queue_cmd(cdb_pkg::CMD_POP_BACK, 0, '0);
        queue_cmd(cdb_pkg::CMD_GET, 0, '0);
        queue_cmd(cdb_pkg::CMD_SET, 0, 32'hFFFF_FFFF);   // append on empty
        queue_cmd(cdb_pkg::CMD_SET, -1, 32'h0000_0000);  // prepend
        queue_cmd(cdb_pkg::CMD_PUSH_FRONT, 0, 32'hA5A5_A5A5);
        queue_cmd(cdb_pkg::CMD_PUSH_BACK, 0, 32'h5A5A_5A5A);
        queue_cmd(cdb_pkg::CMD_GET, 0, '0);
        queue_cmd(cdb_pkg::CMD_GET, 3, '0);
        queue_cmd(cdb_pkg::CMD_GET, 4, '0);              // index equal to count
        queue_cmd(cdb_pkg::CMD_GET, -1, '0);
        queue_cmd(cdb_pkg::CMD_GET, -2048, '0);
        queue_cmd(cdb_pkg::CMD_GET, 2047, '0);
        queue_cmd(cdb_pkg::CMD_SET, 2, 32'hDEAD_BEEF);   // replace
        queue_cmd(cdb_pkg::CMD_GET, 2, '0);
        queue_cmd(cdb_pkg::CMD_SET, 5, 32'h1111_1111);   // beyond count
        queue_cmd(cdb_pkg::CMD_SET, -2, 32'h2222_2222);
        queue_cmd(cdb_pkg::CMD_SET, 4, 32'h3333_3333);   // append at count
        queue_cmd(CMD_SPARE_6, 0, 32'hFFFF_FFFF);
        queue_cmd(CMD_SPARE_7, -1, 32'hFFFF_FFFF);
        queue_cmd(cdb_pkg::CMD_POP_FRONT, 0, '0);
        queue_cmd(cdb_pkg::CMD_POP_BACK, 0, '0);
        queue_cmd(cdb_pkg::CMD_SET, 2047, 32'h4444_4444);
        queue_cmd(cdb_pkg::CMD_POP_FRONT, 0, '0);
        queue_cmd(cdb_pkg::CMD_POP_BACK, 0, '0);
        wait_drained();

        // no idling, with one long receiver hold-off to back up the input
        hold_asks = hold_asks + 1;
        gen_mixed(MIXED_LEN);
        wait_drained();

        // sender gaps only
        send_idle_pct = 45;
        gen_mixed(MIXED_LEN);
        wait_drained();

        // receiver stalls only: fill to full, then hammer the full deque
        send_idle_pct = 0;
        recv_stall_pct = 45;
        fill_to_full();
        queue_cmd(cdb_pkg::CMD_PUSH_FRONT, noise_pos(), rand_word());
        queue_cmd(cdb_pkg::CMD_PUSH_BACK, noise_pos(), rand_word());
        queue_cmd(cdb_pkg::CMD_SET, DEPTH, rand_word());
        queue_cmd(cdb_pkg::CMD_SET, -1, rand_word());
        queue_cmd(cdb_pkg::CMD_GET, DEPTH - 1, '0);
        queue_cmd(cdb_pkg::CMD_GET, DEPTH, '0);
        queue_cmd(cdb_pkg::CMD_SET, DEPTH - 1, rand_word());
        queue_cmd(cdb_pkg::CMD_SET, DEPTH + 1, rand_word());
        queue_cmd(cdb_pkg::CMD_GET, 0, '0);
        queue_cmd(cdb_pkg::CMD_POP_BACK, noise_pos(), '0);
        queue_cmd(cdb_pkg::CMD_POP_FRONT, noise_pos(), '0);
        wait_drained();

        // both sides idling
        send_idle_pct = 25;
        recv_stall_pct = 25;
        gen_mixed(MIXED_LEN);
        wait_drained();

        repeat (END_PAUSE) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_circular_deque_buffer: done, clean");
        else
            $display("tb_circular_deque_buffer: done, errors");
        $finish;
    end

endmodule
